// ===== sv/pwmavg_pkg.sv =====
// shared types, constants and codes for the pwm, adc average and tacho tick block
`timescale 1ns / 1ps
`default_nettype none
package pwmavg_pkg;

  // sample counter width, the sum width follows from it
  localparam int COUNT_WIDTH = 12;
  localparam int SAMPLE_W    = 10;
  localparam int SUM_W       = COUNT_WIDTH + SAMPLE_W;
  localparam int DIV_STEP_W  = $clog2(SUM_W + 1);

  localparam int PERIOD_W = 8;
  localparam int DUTY_W   = 7;
  localparam int NUM_CH   = 3;
  localparam int CH_W     = 2;
  localparam int VAL_W    = 12;
  localparam int CUR_W    = 9;
  localparam int REV_W    = 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX      = '1;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET = 8'd50;

  // channel codes in round-robin order
  localparam logic [CH_W-1:0] CH_GATE1 = 2'd0;
  localparam logic [CH_W-1:0] CH_GATE2 = 2'd1;
  localparam logic [CH_W-1:0] CH_BATT  = 2'd2;

  // opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_DUTY   = 2'd2;

  // scaling by reciprocal: avg*1000/3072 and avg*292/100, exact for 10-bit averages
  localparam int AVG_W  = 10;
  localparam int MUL_W  = 18;
  localparam int PROD_W = AVG_W + MUL_W;
  localparam logic [MUL_W-1:0] CUR_MUL  = 18'd170667;
  localparam int               CUR_SHIFT = 19;
  localparam logic [MUL_W-1:0] VOLT_MUL = 18'd95683;
  localparam int               VOLT_SHIFT = 15;

  typedef struct packed {
    logic [1:0]          opcode;
    logic                gate_select;
    logic [7:0]          duty_value;
    logic [SAMPLE_W-1:0] adc_sample;
    logic                photo_level;
  } item_t;

  typedef struct packed {
    logic             gate1_active;
    logic             gate2_active;
    logic [CUR_W-1:0] gate1_current;
    logic [CUR_W-1:0] gate2_current;
    logic [VAL_W-1:0] battery_voltage;
    logic             window_ready;
    logic [REV_W-1:0] revolutions;
    logic [REV_W-1:0] revolution_ticks;
    logic [CH_W-1:0]  next_channel;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_DIV,
    S_SCALE,
    S_STORE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic            accept;
    logic            start_div;
    logic            scale;
    logic            store;
    logic            commit;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic win_end;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/pwm_adc_average_tacho_tick_core.sv =====
// top level of the pwm, adc window average and tacho tick block
`timescale 1ns / 1ps
`default_nettype none
// Each transaction (tick, adc sample or duty request) yields one result after its state
// update. Samples, duty requests and ticks that do not close a window pass from acceptance
// to the result register through accept, decode and commit. A tick that closes the window
// also runs each of the three channel averages through the shared shift-subtract divider,
// one quotient bit per sum bit, with a start, scale and store step per channel, between
// decode and commit.
// The next transaction is taken while a result waits in the output register; its commit
// then waits until that result is taken. pwm_period is written through cfg_we/cfg_data;
// the user must write it only while the block is idle, the block itself does not enforce it.
module pwm_adc_average_tacho_tick_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire pwmavg_pkg::item_t               item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output pwmavg_pkg::result_t                  result,
  input  wire logic                            cfg_we,
  input  wire logic [pwmavg_pkg::PERIOD_W-1:0] cfg_data
);
  import pwmavg_pkg::*;

  cmd_t    cmd;
  status_t status;

  pwmavg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pwmavg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

endmodule
`default_nettype wire

// ===== sv/pwmavg_div.sv =====
// shift-subtract divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pwmavg_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [pwmavg_pkg::SUM_W-1:0]       dividend,
  input  wire logic [pwmavg_pkg::COUNT_WIDTH-1:0] divisor,
  output logic                                    done,
  output logic [pwmavg_pkg::SUM_W-1:0]            quotient
);
  import pwmavg_pkg::*;

  logic                   busy;
  logic [DIV_STEP_W-1:0]  step;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dsr;
  logic [COUNT_WIDTH:0]   trial;
  logic                   fits;

  assign trial = {rem, quotient[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      if (fits) begin
        rem <= COUNT_WIDTH'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[COUNT_WIDTH-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/pwmavg_ctrl.sv =====
// controller state machine: sequences each transaction and the window-end averaging
`timescale 1ns / 1ps
`default_nettype none
module pwmavg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire pwmavg_pkg::status_t status,
  output pwmavg_pkg::cmd_t         cmd
);
  import pwmavg_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= CH_GATE1;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // nothing is taken while reset is held
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.win_end) begin
          ch_next    = CH_GATE1;
          state_next = S_START;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_START: begin
        cmd.start_div = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (ch == CH_BATT) begin
          state_next = S_COMMIT;
        end else begin
          ch_next    = ch + CH_W'(1);
          state_next = S_START;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // channel walk never leaves the three real channels
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_div || cmd.scale || cmd.store) |-> ch != 2'd3)
    else $error("averaging channel out of range");

endmodule
`default_nettype wire

// ===== sv/pwmavg_dp.sv =====
// datapath: pwm, sample sums, tacho state, divider, scaler and result register
`timescale 1ns / 1ps
`default_nettype none
module pwmavg_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pwmavg_pkg::item_t                   item,
  input  wire pwmavg_pkg::cmd_t                    cmd,
  output pwmavg_pkg::status_t                      status,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output pwmavg_pkg::result_t                      result,
  input  wire logic                                cfg_we,
  input  wire logic [pwmavg_pkg::PERIOD_W-1:0]     cfg_data
);
  import pwmavg_pkg::*;

  item_t                  cur;
  logic [PERIOD_W-1:0]    period;
  logic [PERIOD_W-1:0]    pwm_counter;
  logic [DUTY_W-1:0]      duty_active [2];
  logic [DUTY_W-1:0]      duty_request [2];
  logic [CH_W-1:0]        sample_channel;
  logic [SUM_W-1:0]       sums [NUM_CH];
  logic [COUNT_WIDTH-1:0] counts [NUM_CH];
  logic [VAL_W-1:0]       avg_val [NUM_CH];
  logic [VAL_W-1:0]       avg_tmp [NUM_CH];
  logic [REV_W-1:0]       tick_counter;
  logic [REV_W-1:0]       rev_count;
  logic [REV_W-1:0]       rev_period;
  logic                   photo_previous;
  logic [PROD_W-1:0]      product;

  logic [PERIOD_W-1:0]    pwm_counter_next;
  logic [DUTY_W-1:0]      duty_active_next [2];
  logic [DUTY_W-1:0]      duty_request_next [2];
  logic [CH_W-1:0]        sample_channel_next;
  logic [VAL_W-1:0]       avg_val_next [NUM_CH];
  logic [REV_W-1:0]       tick_counter_next;
  logic [REV_W-1:0]       rev_count_next;
  logic [REV_W-1:0]       rev_period_next;
  logic                   photo_previous_next;
  logic                   clear_win;
  logic                   acc;
  result_t                result_next;

  logic [PERIOD_W-1:0]    pc_inc;
  logic [REV_W-1:0]       tick_inc;
  logic [CH_W-1:0]        rd_ch;
  logic                   rd_ok;
  logic [SUM_W-1:0]       sum_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;
  logic [AVG_W-1:0]       avg_in;
  logic [MUL_W-1:0]       mul;
  logic [PROD_W-1:0]      cur_sh;
  logic [PROD_W-1:0]      volt_sh;

  assign pc_inc   = pwm_counter + PERIOD_W'(1);
  assign tick_inc = tick_counter + REV_W'(1);

  assign status.win_end  = (cur.opcode == OP_TICK) && (pc_inc >= period);
  assign status.div_done = div_done;
  assign status.out_free = !result_valid || result_ready;

  // one read port on the sums: averaging channel on the divider start and scale steps, else the sample channel
  assign rd_ch  = (cmd.start_div || cmd.scale) ? cmd.ch : sample_channel;
  assign rd_ok  = rd_ch != 2'd3;
  assign sum_rd = rd_ok ? sums[rd_ch] : '0;
  assign cnt_rd = rd_ok ? counts[rd_ch] : '0;

  pwmavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (sum_rd),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (quotient)
  );

  // empty window averages to zero
  assign avg_in  = (cnt_rd == '0) ? '0 : quotient[AVG_W-1:0];
  assign mul     = (cmd.ch == CH_BATT) ? VOLT_MUL : CUR_MUL;
  assign cur_sh  = product >> CUR_SHIFT;
  assign volt_sh = product >> VOLT_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= item;
    end
    if (cmd.scale) begin
      product <= PROD_W'(avg_in) * PROD_W'(mul);
    end
    if (cmd.store) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cmd.ch == CH_W'(i)) begin
          avg_tmp[i] <= (cmd.ch == CH_BATT) ? volt_sh[VAL_W-1:0] : cur_sh[VAL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    pwm_counter_next     = pwm_counter;
    duty_active_next[0]  = duty_active[0];
    duty_active_next[1]  = duty_active[1];
    duty_request_next[0] = duty_request[0];
    duty_request_next[1] = duty_request[1];
    sample_channel_next  = sample_channel;
    for (int i = 0; i < NUM_CH; i++) begin
      avg_val_next[i] = avg_val[i];
    end
    tick_counter_next   = tick_counter;
    rev_count_next      = rev_count;
    rev_period_next     = rev_period;
    photo_previous_next = photo_previous;
    clear_win           = 1'b0;
    acc                 = 1'b0;
    case (cur.opcode)
      OP_TICK: begin
        pwm_counter_next = pc_inc;
        if (pc_inc >= period) begin
          pwm_counter_next    = '0;
          duty_active_next[0] = duty_request[0];
          duty_active_next[1] = duty_request[1];
          for (int i = 0; i < NUM_CH; i++) begin
            avg_val_next[i] = avg_tmp[i];
          end
          clear_win = 1'b1;
        end
        tick_counter_next = tick_inc;
        if (cur.photo_level) begin
          if (photo_previous) begin
            rev_count_next    = rev_count + REV_W'(1);
            rev_period_next   = tick_inc;
            tick_counter_next = '0;
          end
          photo_previous_next = 1'b0;
        end else begin
          photo_previous_next = 1'b1;
        end
      end
      OP_SAMPLE: begin
        acc = rd_ok && (cnt_rd != CNT_MAX);
        sample_channel_next = (sample_channel >= CH_BATT) ? CH_GATE1
                                                          : sample_channel + CH_W'(1);
      end
      OP_DUTY: begin
        duty_request_next[cur.gate_select] = cur.duty_value[7:1];
        if (duty_request_next[0] == '0) begin
          duty_active_next[0] = '0;
        end
        if (duty_request_next[1] == '0) begin
          duty_active_next[1] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_next.gate1_active     = {1'b0, duty_active_next[0]} > pwm_counter_next;
    result_next.gate2_active     = {1'b0, duty_active_next[1]} > pwm_counter_next;
    result_next.gate1_current    = avg_val_next[0][CUR_W-1:0];
    result_next.gate2_current    = avg_val_next[1][CUR_W-1:0];
    result_next.battery_voltage  = avg_val_next[2];
    result_next.window_ready     = clear_win;
    result_next.revolutions      = rev_count_next;
    result_next.revolution_ticks = rev_period_next;
    result_next.next_channel     = sample_channel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= PERIOD_RESET;
      pwm_counter     <= '0;
      duty_active[0]  <= '0;
      duty_active[1]  <= '0;
      duty_request[0] <= '0;
      duty_request[1] <= '0;
      sample_channel  <= CH_GATE1;
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i]    <= '0;
        counts[i]  <= '0;
        avg_val[i] <= '0;
      end
      tick_counter   <= '0;
      rev_count      <= '0;
      rev_period     <= '0;
      photo_previous <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        period <= cfg_data;
      end
      if (cmd.commit) begin
        pwm_counter     <= pwm_counter_next;
        duty_active[0]  <= duty_active_next[0];
        duty_active[1]  <= duty_active_next[1];
        duty_request[0] <= duty_request_next[0];
        duty_request[1] <= duty_request_next[1];
        sample_channel  <= sample_channel_next;
        for (int i = 0; i < NUM_CH; i++) begin
          avg_val[i] <= avg_val_next[i];
          if (clear_win) begin
            sums[i]   <= '0;
            counts[i] <= '0;
          end else if (acc && (sample_channel == CH_W'(i))) begin
            sums[i]   <= sums[i] + SUM_W'(cur.adc_sample);
            counts[i] <= counts[i] + COUNT_WIDTH'(1);
          end
        end
        tick_counter   <= tick_counter_next;
        rev_count      <= rev_count_next;
        rev_period     <= rev_period_next;
        photo_previous <= photo_previous_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || result_ready))
    else $error("result register overwritten before transaction");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    sample_channel != 2'd3)
    else $error("sample channel out of range");

  a_ready_pulse: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.win_end) |=> (result_valid && result.window_ready))
    else $error("window end without ready pulse");

endmodule
`default_nettype wire
